/* src/iost_pkg.sv */
// ----------------------------------------------------------------------------
// iost_pkg
// Shared types and codes for the interval origin span table.
// ----------------------------------------------------------------------------
package iost_pkg;

   // address and field widths
   localparam int AddrW = 48;
   localparam int SrcW  = 32;
   localparam int KindW = 2;

   // operation codes
   localparam logic [2:0] OP_WRITE   = 3'd0;
   localparam logic [2:0] OP_CLEAR   = 3'd1;
   localparam logic [2:0] OP_RESOLVE = 3'd2;
   localparam logic [2:0] OP_EXTRACT = 3'd3;
   localparam logic [2:0] OP_RESET   = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNCOV   = 3'd1;
   localparam logic [2:0] ST_CROSS   = 3'd2;
   localparam logic [2:0] ST_UNSUP   = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;
   localparam logic [2:0] ST_RANGE   = 3'd5;

   // origin kind that resolve refuses
   localparam logic [KindW-1:0] KIND_OTHER = 2'd3;

   // most pieces one extract returns
   localparam int RES_MAX = 16;
   localparam int NP_W    = 5;

   // one past the top of the address space
   localparam logic [AddrW:0] ADDR_LIM = {1'b1, {AddrW{1'b0}}};

   // one stored span, also used for a result piece
   typedef struct packed {
      logic [AddrW-1:0] start;
      logic [AddrW-1:0] len;
      logic [KindW-1:0] kind;
      logic [SrcW-1:0]  source;
      logic [AddrW-1:0] payload;
   } span_type;

endpackage

/* src/iost_req_if.sv */
// ----------------------------------------------------------------------------
// iost_req_if
// Request channel: one operation on the span table per beat.
// ----------------------------------------------------------------------------
interface iost_req_if;
   import iost_pkg::*;

   logic             valid;
   logic             ready;
   logic [2:0]       opcode;
   logic [AddrW-1:0] range_start;
   logic [AddrW-1:0] range_length;
   logic [KindW-1:0] origin_kind;
   logic [SrcW-1:0]  origin_source;
   logic [AddrW-1:0] origin_payload;
   logic [AddrW-1:0] target_start;

   modport source (
      output valid, opcode, range_start, range_length, origin_kind,
             origin_source, origin_payload, target_start,
      input  ready
   );
   modport sink (
      input  valid, opcode, range_start, range_length, origin_kind,
             origin_source, origin_payload, target_start,
      output ready
   );
endinterface

/* src/iost_rsp_if.sv */
// ----------------------------------------------------------------------------
// iost_rsp_if
// Response channel: one status or piece per beat.
// ----------------------------------------------------------------------------
interface iost_rsp_if;
   import iost_pkg::*;

   logic             valid;
   logic             ready;
   logic [2:0]       status;
   logic             piece_valid;
   logic [KindW-1:0] piece_kind;
   logic [SrcW-1:0]  piece_source;
   logic [AddrW-1:0] piece_payload;
   logic [AddrW-1:0] piece_start;
   logic [AddrW-1:0] piece_length;
   logic             last_piece;

   modport source (
      output valid, status, piece_valid, piece_kind, piece_source,
             piece_payload, piece_start, piece_length, last_piece,
      input  ready
   );
   modport sink (
      input  valid, status, piece_valid, piece_kind, piece_source,
             piece_payload, piece_start, piece_length, last_piece,
      output ready
   );
endinterface

/* src/interval_origin_span_table_core.sv */
// ----------------------------------------------------------------------------
// interval_origin_span_table_core
// Sorted table of address spans with write, clear, resolve and extract.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per beat; rsp returns one beat per operation,
//   or one beat per extracted piece (up to 16), with last_piece on the final.
//   Spans live in a ping-pong memory of two banks of MAX_SPANS entries; the
//   live bank is read one entry at a time, a write or clear streams the
//   rebuilt table into the other bank and flips the banks at the end unless it overflows.
//   Steps: each span scanned goes through a read, a load and a classify
//   step; a write or clear also passes through the push state for each
//   segment it appends (0 to 3 for one span, at most n + 2 in all, for n
//   stored spans). Resolve and extract only scan and push nothing.
//   Reset-table, zero-length and rejected ops go straight to the final
//   beat. The single-port scan of the span memory sets the rate.
//   One operation is in flight at a time; req.ready is high only when idle.
//   Results sit in an output register, so the next request is taken while
//   the last result of the previous one still waits on rsp.ready.
//   Reset empties the table; memory contents are not cleared.
//   A stalled receiver holds the result beat and pauses the scan.
// ----------------------------------------------------------------------------
module interval_origin_span_table_core #(
   parameter int MAX_SPANS = 16
) (
   input  logic       clock,
   input  logic       reset,
   iost_req_if.sink   req,
   iost_rsp_if.source rsp
);
   import iost_pkg::*;

   localparam int IDX_W = $clog2(MAX_SPANS);
   localparam int CNT_W = $clog2(MAX_SPANS + 1);
   localparam int DEPTH = 2 * (1 << IDX_W);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RD    = 7'b0000010,
      S_LD    = 7'b0000100,
      S_CL    = 7'b0001000,
      S_PUSH  = 7'b0010000,
      S_FLUSH = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // push selection bits
   localparam int M_L = 0;
   localparam int M_I = 1;
   localparam int M_W = 2;
   localparam int M_R = 3;

   state_type state_ff, state_in;

   // item fields
   logic [2:0]       op_ff, op_in;
   logic [AddrW-1:0] rs_ff, rs_in, rl_ff, rl_in, ts_ff, ts_in;
   logic [AddrW:0]   re_ff, re_in;
   span_type         w_ff, w_in;
   logic [AddrW-1:0] w_pend_ff, w_pend_in;

   // table
   span_type         mem [DEPTH];
   span_type         rd_ff;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             mem_we;
   logic [IDX_W:0]   mem_waddr, mem_raddr;
   span_type         mem_wdata;

   // scan
   logic [CNT_W-1:0] idx_ff, idx_in;
   span_type         o_ff, o_in;
   logic [AddrW:0]   oe_ff, oe_in, oers_ff, oers_in;
   logic [AddrW-1:0] opn_ff, opn_in, ds_ff, ds_in, dr_ff, dr_in, es_ff, es_in;

   // rebuild
   logic [3:0]       mask_ff, mask_in;
   logic [AddrW-1:0] l_pend_ff, l_pend_in, r_pay_ff, r_pay_in, r_len_ff, r_len_in;
   logic             end_scan_ff, end_scan_in, placed_ff, placed_in;
   span_type         tail_ff, tail_in;
   logic [AddrW:0]   tail_end_ff, tail_end_in;
   logic [AddrW-1:0] tail_pend_ff, tail_pend_in;
   logic             tail_v_ff, tail_v_in, over_ff, over_in;
   logic [CNT_W-1:0] scnt_ff, scnt_in;

   // results
   logic [2:0]       fin_ff, fin_in;
   logic             pend_v_ff, pend_v_in;
   span_type         pend_ff, pend_in;
   logic [NP_W-1:0]  np_ff, np_in;

   // output register
   logic             out_v_ff, out_v_in, out_pv_ff, out_pv_in, out_last_ff, out_last_in;
   logic [2:0]       out_st_ff, out_st_in;
   span_type         out_pc_ff, out_pc_in;
   logic             out_free;

   // push candidate
   span_type         cand;
   logic [AddrW:0]   cand_end;
   logic [AddrW-1:0] cand_pend;
   logic             merge;
   logic [3:0]       mask_rest;
   logic [CNT_W-1:0] scnt_m1;

   // extract piece helpers
   logic             after, oe_lt;
   span_type         xpc;

   // classify helpers
   logic             c_left, c_right, c_lb, c_rr;

   assign out_free  = !out_v_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign mem_raddr = {bank_ff, idx_ff[IDX_W-1:0]};
   assign scnt_m1   = scnt_ff - CNT_W'(1);

   assign c_left  = (oe_ff <= {1'b0, rs_ff});
   assign c_right = ({1'b0, o_ff.start} >= re_ff);
   assign c_lb    = (o_ff.start < rs_ff);
   assign c_rr    = (re_ff < oe_ff);

   // candidate selection for the push step
   always_comb begin
      cand      = o_ff;
      cand_end  = oe_ff;
      cand_pend = opn_ff;
      if (mask_ff[M_L]) begin
         cand.len  = ds_ff;
         cand_end  = {1'b0, rs_ff};
         cand_pend = l_pend_ff;
      end else if (mask_ff[M_I]) begin
         cand      = w_ff;
         cand_end  = re_ff;
         cand_pend = w_pend_ff;
      end else if (mask_ff[M_R]) begin
         cand.start   = re_ff[AddrW-1:0];
         cand.len     = r_len_ff;
         cand.payload = r_pay_ff;
      end
   end

   assign merge = tail_v_ff && (tail_end_ff == {1'b0, cand.start})
                  && (tail_ff.kind == cand.kind) && (tail_ff.source == cand.source)
                  && (tail_pend_ff == cand.payload);
   assign mask_rest = mask_ff & (mask_ff - 4'd1);

   // extract piece from the current span
   assign after = (o_ff.start > rs_ff);
   assign oe_lt = (oe_ff < re_ff);
   always_comb begin
      xpc         = o_ff;
      xpc.payload = after ? o_ff.payload : o_ff.payload + ds_ff;
      xpc.start   = after ? ts_ff + es_ff : ts_ff;
      if (oe_lt) xpc.len = after ? o_ff.len : oers_ff[AddrW-1:0];
      else       xpc.len = after ? dr_ff : rl_ff;
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rs_in        = rs_ff;
      rl_in        = rl_ff;
      ts_in        = ts_ff;
      re_in        = re_ff;
      w_in         = w_ff;
      w_pend_in    = w_pend_ff;
      bank_in      = bank_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      o_in         = o_ff;
      oe_in        = oe_ff;
      oers_in      = oers_ff;
      opn_in       = opn_ff;
      ds_in        = ds_ff;
      dr_in        = dr_ff;
      es_in        = es_ff;
      mask_in      = mask_ff;
      l_pend_in    = l_pend_ff;
      r_pay_in     = r_pay_ff;
      r_len_in     = r_len_ff;
      end_scan_in  = end_scan_ff;
      placed_in    = placed_ff;
      tail_in      = tail_ff;
      tail_end_in  = tail_end_ff;
      tail_pend_in = tail_pend_ff;
      tail_v_in    = tail_v_ff;
      over_in      = over_ff;
      scnt_in      = scnt_ff;
      fin_in       = fin_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      np_in        = np_ff;
      out_v_in     = out_v_ff && !rsp.ready;
      out_pv_in    = out_pv_ff;
      out_last_in  = out_last_ff;
      out_st_in    = out_st_ff;
      out_pc_in    = out_pc_ff;
      mem_we       = 1'b0;
      mem_waddr    = {!bank_ff, scnt_m1[IDX_W-1:0]};
      mem_wdata    = tail_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in          = req.opcode;
               rs_in          = req.range_start;
               rl_in          = req.range_length;
               ts_in          = req.target_start;
               re_in          = {1'b0, req.range_start} + {1'b0, req.range_length};
               w_in.start     = req.range_start;
               w_in.len       = req.range_length;
               w_in.kind      = req.origin_kind;
               w_in.source    = req.origin_source;
               w_in.payload   = req.origin_payload;
               w_pend_in      = req.origin_payload + req.range_length;
               placed_in      = (req.opcode != OP_WRITE);
               end_scan_in    = 1'b0;
               idx_in         = '0;
               scnt_in        = '0;
               tail_v_in      = 1'b0;
               over_in        = 1'b0;
               np_in          = '0;
               pend_v_in      = 1'b0;
               fin_in         = ST_OK;
               state_in       = S_DONE;
               if (req.opcode > OP_RESET) begin
                  fin_in = ST_RANGE;
               end else if (req.opcode == OP_RESET) begin
                  cnt_in = '0;
               end else if (re_in > ADDR_LIM
                            || (req.opcode == OP_RESOLVE && req.range_length == '0)) begin
                  fin_in = ST_RANGE;
               end else if (req.range_length != '0) begin
                  state_in = S_RD;
               end
            end
         end

         // issue a read or close the scan
         S_RD: begin
            if (idx_ff < cnt_ff) begin
               state_in = S_LD;
            end else if (op_ff == OP_RESOLVE) begin
               fin_in   = ST_UNCOV;
               state_in = S_DONE;
            end else if (op_ff == OP_EXTRACT) begin
               state_in = S_DONE;
            end else if (!placed_ff) begin
               mask_in     = 4'b0001 << M_I;
               placed_in   = 1'b1;
               end_scan_in = 1'b1;
               state_in    = S_PUSH;
            end else begin
               state_in = S_FLUSH;
            end
         end

         // span arrives: ends and offsets
         S_LD: begin
            o_in     = rd_ff;
            oe_in    = {1'b0, rd_ff.start} + {1'b0, rd_ff.len};
            oers_in  = {1'b0, rd_ff.start} + {1'b0, rd_ff.len} - {1'b0, rs_ff};
            opn_in   = rd_ff.payload + rd_ff.len;
            ds_in    = rs_ff - rd_ff.start;
            dr_in    = re_ff[AddrW-1:0] - rd_ff.start;
            es_in    = rd_ff.start - rs_ff;
            state_in = S_CL;
         end

         // classify the span against the range
         S_CL: begin
            if (op_ff == OP_RESOLVE) begin
               if (c_left) begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
                  if (o_ff.start > rs_ff)           fin_in = ST_UNCOV;
                  else if (re_ff > oe_ff)           fin_in = ST_CROSS;
                  else if (o_ff.kind == KIND_OTHER) fin_in = ST_UNSUP;
                  else begin
                     pend_v_in       = 1'b1;
                     pend_in         = o_ff;
                     pend_in.payload = o_ff.payload + ds_ff;
                     pend_in.start   = rs_ff;
                     pend_in.len     = rl_ff;
                  end
               end
            end else if (op_ff == OP_EXTRACT) begin
               if (c_left) begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_RD;
               end else if (c_right) begin
                  state_in = S_DONE;
               end else if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     out_v_in    = 1'b1;
                     out_pv_in   = 1'b1;
                     out_last_in = 1'b0;
                     out_st_in   = ST_OK;
                     out_pc_in   = pend_ff;
                  end
                  pend_v_in = 1'b1;
                  pend_in   = xpc;
                  np_in     = np_ff + NP_W'(1);
                  idx_in    = idx_ff + CNT_W'(1);
                  state_in  = (np_ff == NP_W'(RES_MAX - 1)) ? S_DONE : S_RD;
               end
            end else begin
               l_pend_in = o_ff.payload + ds_ff;
               r_pay_in  = o_ff.payload + dr_ff;
               r_len_in  = oe_ff[AddrW-1:0] - re_ff[AddrW-1:0];
               idx_in    = idx_ff + CNT_W'(1);
               if (c_left) begin
                  mask_in = 4'b0001 << M_W;
               end else if (c_right) begin
                  mask_in   = (4'b0001 << M_W) | (placed_ff ? 4'b0000 : 4'b0001 << M_I);
                  placed_in = 1'b1;
               end else begin
                  mask_in   = (c_lb ? 4'b0001 << M_L : 4'b0000)
                              | (placed_ff ? 4'b0000 : 4'b0001 << M_I)
                              | (c_rr ? 4'b0001 << M_R : 4'b0000);
                  placed_in = 1'b1;
               end
               state_in = (mask_in == 4'b0000) ? S_RD : S_PUSH;
            end
         end

         // append one segment, merging with the tail when it continues
         S_PUSH: begin
            if (merge) begin
               tail_in.len  = tail_ff.len + cand.len;
               tail_end_in  = cand_end;
               tail_pend_in = cand_pend;
            end else if (!over_ff) begin
               if (scnt_ff == CNT_W'(MAX_SPANS)) begin
                  over_in = 1'b1;
               end else begin
                  mem_we       = tail_v_ff;
                  tail_in      = cand;
                  tail_end_in  = cand_end;
                  tail_pend_in = cand_pend;
                  tail_v_in    = 1'b1;
                  scnt_in      = scnt_ff + CNT_W'(1);
               end
            end
            mask_in = mask_rest;
            if (mask_rest == 4'b0000) state_in = end_scan_ff ? S_FLUSH : S_RD;
         end

         // write the tail and swap banks, or report a full table on overflow
         S_FLUSH: begin
            if (over_ff) begin
               fin_in = ST_FULL;
            end else begin
               mem_we  = tail_v_ff;
               bank_in = !bank_ff;
               cnt_in  = scnt_ff;
            end
            state_in = S_DONE;
         end

         // final beat of the operation
         S_DONE: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_pv_in   = pend_v_ff;
               out_last_in = 1'b1;
               out_st_in   = fin_ff;
               out_pc_in   = pend_v_ff ? pend_ff : '0;
               pend_v_in   = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // span memory, two banks
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         bank_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         tail_v_ff <= 1'b0;
         over_ff   <= 1'b0;
         scnt_ff   <= '0;
         mask_ff   <= '0;
         idx_ff    <= '0;
         np_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         bank_ff   <= bank_in;
         out_v_ff  <= out_v_in;
         pend_v_ff <= pend_v_in;
         tail_v_ff <= tail_v_in;
         over_ff   <= over_in;
         scnt_ff   <= scnt_in;
         mask_ff   <= mask_in;
         idx_ff    <= idx_in;
         np_ff     <= np_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rs_ff        <= rs_in;
      rl_ff        <= rl_in;
      ts_ff        <= ts_in;
      re_ff        <= re_in;
      w_ff         <= w_in;
      w_pend_ff    <= w_pend_in;
      o_ff         <= o_in;
      oe_ff        <= oe_in;
      oers_ff      <= oers_in;
      opn_ff       <= opn_in;
      ds_ff        <= ds_in;
      dr_ff        <= dr_in;
      es_ff        <= es_in;
      l_pend_ff    <= l_pend_in;
      r_pay_ff     <= r_pay_in;
      r_len_ff     <= r_len_in;
      end_scan_ff  <= end_scan_in;
      placed_ff    <= placed_in;
      tail_ff      <= tail_in;
      tail_end_ff  <= tail_end_in;
      tail_pend_ff <= tail_pend_in;
      fin_ff       <= fin_in;
      pend_ff      <= pend_in;
      out_pv_ff    <= out_pv_in;
      out_last_ff  <= out_last_in;
      out_st_ff    <= out_st_in;
      out_pc_ff    <= out_pc_in;
   end

   // response port
   assign rsp.valid         = out_v_ff;
   assign rsp.status        = out_st_ff;
   assign rsp.piece_valid   = out_pv_ff;
   assign rsp.piece_kind    = out_pc_ff.kind;
   assign rsp.piece_source  = out_pc_ff.source;
   assign rsp.piece_payload = out_pc_ff.payload;
   assign rsp.piece_start   = out_pc_ff.start;
   assign rsp.piece_length  = out_pc_ff.len;
   assign rsp.last_piece    = out_last_ff;

   // table size stays within capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SPANS))
      else $error("span count above capacity");

   // rebuild never stores beyond capacity
   a_scnt_bound: assert property (@(posedge clock) disable iff (reset)
      scnt_ff <= CNT_W'(MAX_SPANS))
      else $error("rebuild count above capacity");

   // a failed rebuild leaves the live table alone
   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && over_ff) |=> (cnt_ff == $past(cnt_ff)
                                           && bank_ff == $past(bank_ff)))
      else $error("table changed on overflow");

   // extract never collects more than the piece limit
   a_np_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CL && op_ff == OP_EXTRACT) |-> np_ff < NP_W'(RES_MAX))
      else $error("extract piece count overrun");

endmodule
